/* hdl/qdrp_pkg.sv */
package qdrp_pkg;

    localparam logic [25:0] RATE_MIN = 26'd500000;
    localparam logic [25:0] RATE_MAX = 26'd34800000;
    localparam logic [25:0] XTAL_D16 = 26'd4350000;
    localparam logic [25:0] XTAL_D32 = 26'd2175000;
    localparam logic [25:0] XTAL_D64 = 26'd1087500;
    localparam logic [25:0] SF_T0 = 26'd5658536;
    localparam logic [25:0] SF_T1 = 26'd2829268;
    localparam logic [25:0] SF_T2 = 26'd1414634;
    localparam logic [25:0] SF_T3 = 26'd707317;
    localparam logic [23:0] FIN_HZ = 24'd4350000;
    localparam logic [30:0] FIN_HALF = 31'd2175000;
    // ceil(2^54 / FIN_HZ): exact quotient for any dividend below 2^31
    localparam logic [31:0] RATIO_RECIP = 32'd4141241037;
    localparam logic [35:0] XTAL_X16 = 36'd1113600000;
    localparam logic [7:0] REG3_BASE = 8'h0A;
    localparam logic [7:0] REG14_BASE = 8'h63;
    localparam logic [7:0] REG0_BASE = 8'h49;
    localparam logic [7:0] PWM_RESET = 8'd72;
    localparam logic [2:0] QAM_MAX = 3'd4;

    // One classified request as handed from front to back
    typedef struct packed {
        logic        qam_bad;
        logic        inv_bad;
        logic [2:0]  qam;
        logic        inv;
        logic [1:0]  ndec;
        logic        sfil;
        logic [28:0] srate;
    } qdrp_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } qdrp_state_t;

    // QAM table: rows per order, columns for registers 0x01, 0x05, 0x08, 0x09
    function automatic logic [7:0] qam_tab(input logic [2:0] q, input logic [1:0] c);
        logic [7:0] v;
        v = 8'd0;
        case (q)
            3'd0: case (c) 2'd0: v = 8'd145; 2'd1: v = 8'd164; 2'd2: v = 8'd162;
                  default: v = 8'd145; endcase
            3'd1: case (c) 2'd0: v = 8'd150; 2'd1: v = 8'd120; 2'd2: v = 8'd116;
                  default: v = 8'd150; endcase
            3'd2: case (c) 2'd0: v = 8'd106; 2'd1: v = 8'd70; 2'd2: v = 8'd67;
                  default: v = 8'd106; endcase
            3'd3: case (c) 2'd0: v = 8'd126; 2'd1: v = 8'd54; 2'd2: v = 8'd52;
                  default: v = 8'd126; endcase
            default: case (c) 2'd0: v = 8'd107; 2'd1: v = 8'd38; 2'd2: v = 8'd35;
                  default: v = 8'd107; endcase
        endcase
        return v;
    endfunction

endpackage

/* hdl/qdrp_front.sv */
module qdrp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [25:0]            symbol_rate,
    input  logic [2:0]             qam_order,
    input  logic [1:0]             inversion_mode,
    output logic                   req_valid,
    input  logic                   req_stall,
    output qdrp_pkg::qdrp_req_t    req
);

    qdrp_pkg::qdrp_req_t q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [25:0] rate;
    logic [1:0]  ndec;
    logic        sfil;
    qdrp_pkg::qdrp_req_t cls;
    logic push, pop;

    // Clamp and classify the rate
    always_comb
    begin
        rate = symbol_rate;
        if (rate > qdrp_pkg::RATE_MAX) rate = qdrp_pkg::RATE_MAX;
        if (rate < qdrp_pkg::RATE_MIN) rate = qdrp_pkg::RATE_MIN;
        ndec = 2'd0;
        if (rate < qdrp_pkg::XTAL_D16) ndec = 2'd1;
        if (rate < qdrp_pkg::XTAL_D32) ndec = 2'd2;
        if (rate < qdrp_pkg::XTAL_D64) ndec = 2'd3;
        sfil = 1'b0;
        if (rate < qdrp_pkg::SF_T0) sfil = 1'b1;
        if (rate < qdrp_pkg::XTAL_D16) sfil = 1'b0;
        if (rate < qdrp_pkg::SF_T1) sfil = 1'b1;
        if (rate < qdrp_pkg::XTAL_D32) sfil = 1'b0;
        if (rate < qdrp_pkg::SF_T2) sfil = 1'b1;
        if (rate < qdrp_pkg::XTAL_D64) sfil = 1'b0;
        if (rate < qdrp_pkg::SF_T3) sfil = 1'b1;
        cls.qam_bad = qam_order > qdrp_pkg::QAM_MAX;
        cls.inv_bad = inversion_mode[1];
        cls.qam = qam_order;
        cls.inv = inversion_mode[0];
        cls.ndec = ndec;
        cls.sfil = sfil;
        cls.srate = {3'd0, rate} << ndec;
    end

    // Two-entry queue between front and back
    assign in_stall  = cnt_reg == 2'd2;
    assign push      = in_valid && !in_stall;
    assign req_valid = cnt_reg != 2'd0;
    assign pop       = req_valid && !req_stall;
    assign req       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* hdl/qdrp_back.sv */
module qdrp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             pwm,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  qdrp_pkg::qdrp_req_t    req,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [5:0]             reg_addr,
    output logic [7:0]             reg_data,
    output logic                   error_flag,
    output logic                   last_result
);

    qdrp_pkg::qdrp_state_t state_reg, state_next;
    qdrp_pkg::qdrp_req_t r_reg;
    logic [5:0]  step_reg, step_next;
    logic [30:0] rx_reg;       // partial dividend of the current ratio byte
    logic [62:0] prod_reg;
    logic [8:0]  dig_reg;
    logic [21:0] ratio_reg;
    logic [35:0] bnum_reg;     // dividend for inverse baud
    logic [29:0] brem_reg;
    logic [7:0]  bquo_reg;
    logic        bsat_reg;
    logic [7:0]  pwm_reg;
    logic [4:0]  idx_reg, idx_next;
    logic        load, iter;
    logic [30:0] rx_rem, rx_nx;
    logic [21:0] ratio_nx;
    logic [29:0] brem_sh, brem_nx;
    logic [7:0]  bdri, reg0;
    logic [5:0]  a_n;
    logic [7:0]  d_n;
    logic        e_n, l_n, out_free;

    assign out_free = !out_valid || !out_stall;

    // Baud ratio: three byte digits of s<<4 over FIN_HZ by reciprocal multiply,
    // half a divisor added before the last digit for rounding
    // Inverse baud: XTAL*16 + s/2 divided by s, 8 quotient bits plus saturation
    always_comb
    begin
        rx_rem   = rx_reg - 31'(dig_reg) * 31'(qdrp_pkg::FIN_HZ);
        rx_nx    = {rx_rem[22:0], 8'd0} + ((step_reg == 6'd5) ? qdrp_pkg::FIN_HALF : 31'd0);
        ratio_nx = {ratio_reg[13:0], 8'd0} + {13'd0, dig_reg};
        brem_sh = {brem_reg[28:0], bnum_reg[35]};
        brem_nx = (brem_sh >= {1'b0, r_reg.srate}) ? brem_sh - {1'b0, r_reg.srate} : brem_sh;
        bdri    = bsat_reg ? 8'hFF : bquo_reg;
        reg0    = (qdrp_pkg::REG0_BASE & 8'hE3) | {3'd0, r_reg.qam, 2'd0};
        reg0    = r_reg.inv ? (reg0 | 8'h20) : (reg0 & 8'hDF);
    end

    // Control: load, 36 divide steps, then emit words; a bad QAM order skips the steps
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        req_stall  = 1'b1;
        load = 1'b0;
        iter = 1'b0;
        unique case (state_reg)
            qdrp_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    load = 1'b1;
                    idx_next = 5'd0;
                    step_next = 6'd0;
                    state_next = req.qam_bad ? qdrp_pkg::ST_EMIT : qdrp_pkg::ST_CALC;
                end
            end
            qdrp_pkg::ST_CALC:
            begin
                iter = 1'b1;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd35) state_next = qdrp_pkg::ST_EMIT;
            end
            qdrp_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    if (l_n) state_next = qdrp_pkg::ST_IDLE;
                    idx_next = idx_reg + 5'd1;
                end
            end
            default: state_next = qdrp_pkg::ST_IDLE;
        endcase
    end

    // Select the word for the current index
    always_comb
    begin
        a_n = 6'h00; d_n = 8'h00; e_n = 1'b0; l_n = 1'b0;
        if (r_reg.qam_bad)
        begin
            e_n = 1'b1; l_n = 1'b1;
        end
        else
        begin
            case (idx_reg)
                5'd0: begin a_n = 6'h03; d_n = {r_reg.ndec, 6'd0} | qdrp_pkg::REG3_BASE; end
                5'd1: begin a_n = 6'h0A; d_n = ratio_reg[7:0]; end
                5'd2: begin a_n = 6'h0B; d_n = ratio_reg[15:8]; end
                5'd3: begin a_n = 6'h0C; d_n = {2'd0, ratio_reg[21:16]}; end
                5'd4: begin a_n = 6'h0D; d_n = bdri; end
                5'd5: begin a_n = 6'h0E; d_n = {3'd0, r_reg.sfil, 4'd0} | qdrp_pkg::REG14_BASE; end
                5'd6: begin a_n = 6'h34; d_n = pwm_reg; end
                5'd7: begin a_n = 6'h01; d_n = qdrp_pkg::qam_tab(r_reg.qam, 2'd0); end
                5'd8: begin a_n = 6'h05; d_n = qdrp_pkg::qam_tab(r_reg.qam, 2'd1); end
                5'd9: begin a_n = 6'h08; d_n = qdrp_pkg::qam_tab(r_reg.qam, 2'd2); end
                5'd10: begin a_n = 6'h09; d_n = qdrp_pkg::qam_tab(r_reg.qam, 2'd3); end
                5'd11:
                begin
                    if (r_reg.inv_bad)
                    begin
                        e_n = 1'b1; l_n = 1'b1;
                    end
                    else
                    begin
                        a_n = 6'h00; d_n = reg0 & 8'hFE;
                    end
                end
                default: begin a_n = 6'h00; d_n = reg0; l_n = 1'b1; end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r_reg     <= req;
            pwm_reg   <= pwm;
            rx_reg    <= {req.srate[26:0], 4'd0};
            ratio_reg <= 22'd0;
            bnum_reg  <= qdrp_pkg::XTAL_X16 + {8'd0, req.srate[28:1]};
            brem_reg  <= 30'd0;
            bquo_reg  <= 8'd0;
            bsat_reg  <= 1'b0;
        end
        else if (iter)
        begin
            // Multiply, take the digit, then advance remainder and ratio
            case (step_reg) inside
                6'd0, 6'd3, 6'd6: prod_reg <= 63'(rx_reg) * 63'(qdrp_pkg::RATIO_RECIP);
                6'd1, 6'd4, 6'd7: dig_reg <= prod_reg[62:54];
                6'd2, 6'd5, 6'd8:
                begin
                    rx_reg    <= rx_nx;
                    ratio_reg <= ratio_nx;
                end
                default: ;
            endcase
            bnum_reg <= {bnum_reg[34:0], 1'b0};
            brem_reg <= brem_nx;
            if (step_reg >= 6'd28) bquo_reg <= {bquo_reg[6:0], brem_sh >= {1'b0, r_reg.srate}};
            else if (brem_sh >= {1'b0, r_reg.srate}) bsat_reg <= 1'b1;
        end
        if (state_reg == qdrp_pkg::ST_EMIT && out_free)
        begin
            reg_addr    <= a_n;
            reg_data    <= d_n;
            error_flag  <= e_n;
            last_result <= l_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qdrp_pkg::ST_IDLE;
            step_reg  <= 6'd0;
            idx_reg   <= 5'd0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            if (state_reg == qdrp_pkg::ST_EMIT && out_free) out_valid <= 1'b1;
            else if (!out_stall) out_valid <= 1'b0;
        end
    end

endmodule

/* hdl/qam_demod_register_programmer.sv */
// The back end takes one request at a time: it loads it, runs the serial division
// (one dividend bit per step over a 36-bit dividend), then emits 13 result words,
// or fewer ending in an error word when a code is bad, before it takes the next.
// The front end queues up to two requests, so input is taken while results drain.
// Reset (rst_n, asynchronous, active low) empties the queue and sets the PWM level register to 72.
module qam_demod_register_programmer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [25:0] symbol_rate,
    input  logic [2:0]  qam_order,
    input  logic [1:0]  inversion_mode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  reg_addr,
    output logic [7:0]  reg_data,
    output logic        error_flag,
    output logic        last_result
);

    logic [7:0] pwm_reg;
    logic req_valid, req_stall;
    qdrp_pkg::qdrp_req_t req;

    // Hold the PWM level register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) pwm_reg <= qdrp_pkg::PWM_RESET;
        else if (cfg_we) pwm_reg <= cfg_data;
    end

    qdrp_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .symbol_rate, .qam_order,
        .inversion_mode, .req_valid, .req_stall, .req
    );

    qdrp_back u_back (
        .clk, .rst_n, .pwm(pwm_reg), .req_valid, .req_stall, .req,
        .out_valid, .out_stall, .reg_addr, .reg_data, .error_flag, .last_result
    );

    // An error word always closes its request
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_flag |-> last_result)
        else $error("error word without last flag");

    // An error word carries no write
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_flag |-> reg_addr == 6'd0 && reg_data == 8'd0)
        else $error("error word carries data");

    // A full queue stalls the input
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> req_valid)
        else $error("queue full while empty");

endmodule

/* tb/sv/qdrp_checker.sv */
module qdrp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [25:0] symbol_rate,
    input  logic [2:0]  qam_order,
    input  logic [1:0]  inversion_mode,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  reg_addr,
    input  logic [7:0]  reg_data,
    input  logic        error_flag,
    input  logic        last_result,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [5:0] addr;
        logic [7:0] data;
        logic       err;
        logic       last;
    } reg_write_t;

    reg_write_t write_q[$];
    logic [7:0] pwm_shadow;

    function automatic logic [7:0] table_byte(input logic [2:0] q, input int c);
        logic [7:0] row[5][4];
        row = '{'{8'd145, 8'd164, 8'd162, 8'd145}, '{8'd150, 8'd120, 8'd116, 8'd150},
                '{8'd106, 8'd70, 8'd67, 8'd106}, '{8'd126, 8'd54, 8'd52, 8'd126},
                '{8'd107, 8'd38, 8'd35, 8'd107}};
        return row[q][c];
    endfunction

    // Build the register write sequence for one tuning request
    task automatic predict_writes(input logic [25:0] sr, input logic [2:0] q,
                                  input logic [1:0] inv);
        logic [63:0] rate, s, ratio, rem, bdri;
        logic [1:0]  ndec;
        logic        sfil;
        logic [7:0]  reg0;
        if (q > 3'd4) begin
            write_q.push_back('{6'd0, 8'd0, 1'b1, 1'b1});
            return;
        end
        rate = 64'(sr);
        if (rate > 64'd34800000) rate = 64'd34800000;
        if (rate < 64'd500000) rate = 64'd500000;
        ndec = 2'd0;
        if (rate < 64'd4350000) ndec = 2'd1;
        if (rate < 64'd2175000) ndec = 2'd2;
        if (rate < 64'd1087500) ndec = 2'd3;
        sfil = 1'b0;
        if (rate < 64'd5658536) sfil = 1'b1;
        if (rate < 64'd4350000) sfil = 1'b0;
        if (rate < 64'd2829268) sfil = 1'b1;
        if (rate < 64'd2175000) sfil = 1'b0;
        if (rate < 64'd1414634) sfil = 1'b1;
        if (rate < 64'd1087500) sfil = 1'b0;
        if (rate < 64'd707317) sfil = 1'b1;
        s = rate << ndec;
        ratio = (s << 4) / 64'd4350000;
        rem = ((s << 4) % 64'd4350000) << 8;
        ratio = (ratio << 8) + rem / 64'd4350000;
        rem = (rem % 64'd4350000) << 8;
        ratio = (ratio << 8) + (rem + 64'd2175000) / 64'd4350000;
        bdri = ((64'd2227200000 / s) + 64'd1) / 64'd2;
        if (bdri > 64'd255) bdri = 64'd255;
        write_q.push_back('{6'h03, {ndec, 6'h0A}, 1'b0, 1'b0});
        write_q.push_back('{6'h0A, ratio[7:0], 1'b0, 1'b0});
        write_q.push_back('{6'h0B, ratio[15:8], 1'b0, 1'b0});
        write_q.push_back('{6'h0C, {2'b00, ratio[21:16]}, 1'b0, 1'b0});
        write_q.push_back('{6'h0D, bdri[7:0], 1'b0, 1'b0});
        write_q.push_back('{6'h0E, {3'b000, sfil, 4'h0} | 8'h63, 1'b0, 1'b0});
        write_q.push_back('{6'h34, pwm_shadow, 1'b0, 1'b0});
        write_q.push_back('{6'h01, table_byte(q, 0), 1'b0, 1'b0});
        write_q.push_back('{6'h05, table_byte(q, 1), 1'b0, 1'b0});
        write_q.push_back('{6'h08, table_byte(q, 2), 1'b0, 1'b0});
        write_q.push_back('{6'h09, table_byte(q, 3), 1'b0, 1'b0});
        reg0 = (8'h49 & 8'hE3) | {3'b000, q, 2'b00};
        if (inv > 2'd1) begin
            write_q.push_back('{6'd0, 8'd0, 1'b1, 1'b1});
            return;
        end
        if (inv == 2'd1) reg0 = reg0 | 8'h20;
        else reg0 = reg0 & 8'hDF;
        write_q.push_back('{6'h00, reg0 & 8'hFE, 1'b0, 1'b0});
        write_q.push_back('{6'h00, reg0, 1'b0, 1'b1});
    endtask

    assign pending = write_q.size();

    // Track config, predict on input words, compare output words
    always @(posedge clk or negedge rst_n)
    begin
        reg_write_t exp_w;
        if (!rst_n) begin
            pwm_shadow <= qdrp_pkg::PWM_RESET;
            fail_count <= 0;
            write_q.delete();
        end else begin
            if (cfg_we) pwm_shadow <= cfg_data;
            if (in_valid && !in_stall)
                predict_writes(symbol_rate, qam_order, inversion_mode);
            if (out_valid && !out_stall) begin
                if (write_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected word addr=%h data=%h err=%b last=%b",
                                 reg_addr, reg_data, error_flag, last_result);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = write_q.pop_front();
                    if (exp_w != {reg_addr, reg_data, error_flag, last_result}) begin
                        if (fail_count < 10)
                            $display("mismatch exp addr=%h data=%h err=%b last=%b, got addr=%h data=%h err=%b last=%b",
                                     exp_w.addr, exp_w.data, exp_w.err, exp_w.last,
                                     reg_addr, reg_data, error_flag, last_result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [7:0]  cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [25:0] symbol_rate = 0;
    logic [2:0]  qam_order = 0;
    logic [1:0]  inversion_mode = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [5:0]  reg_addr;
    logic [7:0]  reg_data;
    logic        error_flag;
    logic        last_result;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          calm = 0;

    qam_demod_register_programmer dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .symbol_rate(symbol_rate),
        .qam_order(qam_order), .inversion_mode(inversion_mode),
        .out_valid(out_valid), .out_stall(out_stall), .reg_addr(reg_addr),
        .reg_data(reg_data), .error_flag(error_flag), .last_result(last_result)
    );

    qdrp_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .symbol_rate(symbol_rate),
        .qam_order(qam_order), .inversion_mode(inversion_mode),
        .out_valid(out_valid), .out_stall(out_stall), .reg_addr(reg_addr),
        .reg_data(reg_data), .error_flag(error_flag), .last_result(last_result),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // Stall the result side at random, except during the calm stretch
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 28);
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("qam_demod_register_programmer test failed");
            $finish;
        end
    end

    // Present one word and hold it until accepted; the next call or an idle drops valid
    task automatic send_word(input logic [25:0] sr, input logic [2:0] q,
                             input logic [1:0] inv);
        while (!calm && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol_rate <= sr;
        qam_order <= q;
        inversion_mode <= inv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_pwm(input logic [7:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [25:0] pick_rate();
        case ($urandom_range(5))
            0: return 26'($urandom);
            1: return 26'($urandom_range(600000));
            2: return 26'($urandom_range(34700000, 35000000));
            default: return 26'($urandom_range(400000, 36000000));
        endcase
    endfunction

    initial
    begin
        logic [25:0] edge_rates[12];
        edge_rates = '{26'd0, 26'd499999, 26'd500000, 26'd707316, 26'd707317,
                       26'd1087499, 26'd1414634, 26'd2175000, 26'd2829267,
                       26'd4350000, 26'd34800000, 26'h3FFFFFF};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: rate thresholds, all QAM orders, both bad-code cases
        foreach (edge_rates[i])
            send_word(edge_rates[i], 3'(i % 5), 2'(i % 2));
        for (int q = 0; q < 8; q++)
            send_word(26'd6900000, 3'(q), 2'd1);
        send_word(26'd6900000, 3'd2, 2'd2);
        send_word(26'd6900000, 3'd4, 2'd3);
        write_pwm(8'd0);
        send_word(26'd1000000, 3'd0, 2'd0);
        write_pwm(8'd255);
        send_word(26'd1000000, 3'd1, 2'd1);
        // Random phases, each with a fresh PWM byte
        for (int p = 0; p < 4; p++) begin
            write_pwm(8'($urandom));
            calm = (p == 2);
            for (int k = 0; k < 20; k++)
                send_word(pick_rate(),
                          3'(($urandom_range(9) == 0) ? $urandom_range(5, 7)
                                                      : $urandom_range(4)),
                          2'(($urandom_range(9) == 0) ? $urandom_range(2, 3)
                                                      : $urandom_range(1)));
        end
        calm = 0;
        drain();
        if (fail_count == 0)
            $display("qam_demod_register_programmer test passed");
        else
            $display("qam_demod_register_programmer test failed");
        $finish;
    end
endmodule
